@@ hw/rtl/magic_header_packet_deframer_core_macros.svh @@
// Assertion macros used by the deframer core.
`ifndef MAGIC_HEADER_PACKET_DEFRAMER_CORE_MACROS_SVH
`define MAGIC_HEADER_PACKET_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MHPD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled while reset is high.
`define MHPD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

@@ hw/rtl/mhpd_pkg.sv @@
// Types and constants for the magic-header packet deframer.
package mhpd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic ERR_HEADER_CORRUPT = 1'b0;
  localparam logic ERR_LINK_LOST      = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_EXPECTED_MAGIC  = 1'b0;
  localparam logic REG_MAX_BODY_LENGTH = 1'b1;

  // Register reset values
  localparam logic [31:0] MAGIC_RESET    = 32'hDEAD_BEEF;
  localparam logic [31:0] MAX_LEN_RESET  = 32'd65536;

  // Header layout: seven little-endian words, then reserved bytes
  localparam int HDR_WORDS  = 7;
  localparam int WORD_BYTES = 28;

  typedef logic [HDR_WORDS-1:0][31:0] hdr_words_t;

endpackage

@@ hw/rtl/magic_header_packet_deframer_core.sv @@
// Magic-header packet deframer: byte stream in, header/body/error results out.
//
// Input channel: one received byte per beat (rx_byte, link_lost) on
// in_valid/in_stall. Output channel: one result per beat on out_valid/
// out_stall; result_kind tells a header (with its six words), a body byte
// or an error. Fields that do not belong to the kind read as zero.
// Each input beat is handled by one pass of logic into the output
// register: a result appears in the cycle after its beat is accepted, and a
// beat can be accepted every unstalled cycle (one byte per cycle). Header
// bytes but the last, and link_lost bytes in the header, give no result.
// in_stall is high only while a result waits in the output register and
// out_stall holds it; the pipeline then freezes with no loss.
// Registers over APB: 0x0 expected_magic, 0x4 max_body_length; pready is
// always high. After a corrupted header or a link loss in the body, the
// block stays in its error phase and gives no results until reset.
// Synchronous reset returns to header collection with an empty output.
`include "magic_header_packet_deframer_core_macros.svh"

module magic_header_packet_deframer_core
  import mhpd_pkg::*;
#(
  parameter int HEADER_BYTES = 44
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        link_lost,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [31:0] protocol_version,
  output logic [31:0] sequence_number,
  output logic [31:0] message_type,
  output logic [31:0] body_length,
  output logic [31:0] sender_address,
  output logic [31:0] sender_port,
  output logic [7:0]  body_byte,
  output logic        end_of_packet,
  output logic        error_code
);

  localparam int CNT_W = $clog2(HEADER_BYTES);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;

  // Configuration registers
  logic [31:0] expected_magic;
  logic [31:0] max_body_length;

  // Deframer state
  logic [1:0]       phase, phase_next;
  logic [CNT_W-1:0] hdr_count, hdr_count_next;
  hdr_words_t       words, words_next;
  logic [31:0]      left, left_next;

  // Result computed for the beat being accepted
  logic        produce;
  logic [1:0]  kind_next;
  hdr_words_t  hdr_out_next;
  logic [7:0]  byte_next;
  logic        eop_next;
  logic        err_next;

  logic        accept;
  logic        hdr_done;
  logic        hdr_write;
  logic [31:0] left_dec;

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic  <= MAGIC_RESET;
      max_body_length <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_EXPECTED_MAGIC:  expected_magic  <= pwdata;
        REG_MAX_BODY_LENGTH: max_body_length <= pwdata;
        default:             ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXPECTED_MAGIC:  prdata = expected_magic;
      REG_MAX_BODY_LENGTH: prdata = max_body_length;
      default:             prdata = '0;
    endcase
  end

  // Handshake: stall only while a held result blocks the output register
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign hdr_done  = (hdr_count == CNT_W'(HEADER_BYTES - 1));
  assign hdr_write = (hdr_count < CNT_W'(WORD_BYTES));
  assign left_dec  = (left != '0) ? left - 32'd1 : left;

  // Next state and result for one byte
  always_comb begin
    phase_next     = phase;
    hdr_count_next = hdr_count;
    words_next     = words;
    left_next      = left;
    produce        = 1'b0;
    kind_next      = KIND_HEADER;
    hdr_out_next   = '0;
    byte_next      = '0;
    eop_next       = 1'b0;
    err_next       = ERR_HEADER_CORRUPT;

    unique case (phase)
      PH_HEADER: begin
        if (!link_lost) begin
          if (hdr_write) begin
            words_next[hdr_count[4:2]][{hdr_count[1:0], 3'b000} +: 8] = rx_byte;
          end
          if (!hdr_done) begin
            hdr_count_next = hdr_count + CNT_W'(1);
          end else begin
            hdr_count_next = '0;
            produce        = 1'b1;
            if (words_next[0] != expected_magic || words_next[4] > max_body_length) begin
              kind_next  = KIND_ERROR;
              err_next   = ERR_HEADER_CORRUPT;
              phase_next = PH_ERROR;
            end else begin
              kind_next    = KIND_HEADER;
              hdr_out_next = words_next;
              hdr_out_next[0] = '0;
              left_next    = words_next[4];
              if (words_next[4] == '0) begin
                eop_next = 1'b1;
              end else begin
                phase_next = PH_BODY;
              end
            end
          end
        end
      end
      PH_BODY: begin
        produce = 1'b1;
        if (link_lost) begin
          kind_next  = KIND_ERROR;
          err_next   = ERR_LINK_LOST;
          phase_next = PH_ERROR;
        end else begin
          kind_next = KIND_BODY;
          byte_next = rx_byte;
          left_next = left_dec;
          if (left_dec == '0) begin
            eop_next       = 1'b1;
            phase_next     = PH_HEADER;
            hdr_count_next = '0;
          end
        end
      end
      PH_ERROR: ;
      default:  ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hdr_count <= '0;
      words     <= '0;
      left      <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      hdr_count <= hdr_count_next;
      words     <= words_next;
      left      <= left_next;
    end
  end

  // Output register: valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= produce;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (accept && produce) begin
      result_kind      <= kind_next;
      protocol_version <= hdr_out_next[1];
      sequence_number  <= hdr_out_next[2];
      message_type     <= hdr_out_next[3];
      body_length      <= hdr_out_next[4];
      sender_address   <= hdr_out_next[5];
      sender_port      <= hdr_out_next[6];
      body_byte        <= byte_next;
      end_of_packet    <= eop_next;
      error_code       <= err_next;
    end
  end

  // Assertions
  `MHPD_ASSERT_NXT(a_error_sticky, clk, rst, phase == PH_ERROR, phase == PH_ERROR)
  `MHPD_ASSERT_IMP(a_err_out_phase, clk, rst, out_valid && result_kind == KIND_ERROR, phase == PH_ERROR)
  `MHPD_ASSERT_IMP(a_count_idle, clk, rst, phase != PH_HEADER, hdr_count == '0)
  `MHPD_ASSERT_IMP(a_body_left, clk, rst, phase == PH_BODY, left != '0)

endmodule
